// ----- src/ptt_pkg.sv -----
// Shared types, constants and helpers for the properties text tokenizer.
// Used by every module of the block; depends on nothing else.
package ptt_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int CHAR_WIDTH = 16;
    localparam int REC_MAX    = 4;
    localparam int REC_CNT_W  = $clog2(REC_MAX + 1);

    typedef logic [POS_WIDTH-1:0]  t_pos;
    typedef logic [CHAR_WIDTH-1:0] t_char;

    // Part kinds carried in each record.
    localparam logic [2:0] KIND_BLANKS  = 3'd0;
    localparam logic [2:0] KIND_KEY     = 3'd1;
    localparam logic [2:0] KIND_SEP     = 3'd2;
    localparam logic [2:0] KIND_VALUE   = 3'd3;
    localparam logic [2:0] KIND_COMMENT = 3'd4;

    // Parse modes of the scanner.
    localparam logic [2:0] MODE_LEAD    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_KEY     = 3'd2;
    localparam logic [2:0] MODE_GAP_KEY = 3'd3;
    localparam logic [2:0] MODE_GAP_SEP = 3'd4;
    localparam logic [2:0] MODE_VALUE   = 3'd5;

    // Character codes that steer the parse.
    localparam t_char CH_TAB   = CHAR_WIDTH'(8'h09);
    localparam t_char CH_LF    = CHAR_WIDTH'(8'h0A);
    localparam t_char CH_FF    = CHAR_WIDTH'(8'h0C);
    localparam t_char CH_CR    = CHAR_WIDTH'(8'h0D);
    localparam t_char CH_SPACE = CHAR_WIDTH'(8'h20);
    localparam t_char CH_BANG  = CHAR_WIDTH'(8'h21);
    localparam t_char CH_HASH  = CHAR_WIDTH'(8'h23);
    localparam t_char CH_COLON = CHAR_WIDTH'(8'h3A);
    localparam t_char CH_EQUAL = CHAR_WIDTH'(8'h3D);
    localparam t_char CH_BSL   = CHAR_WIDTH'(8'h5C);

    typedef struct packed {
        logic [15:0] char_code;
        logic        final_char;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  part_kind;
        logic [31:0] part_start;
        logic [31:0] part_length;
        logic        run_end;
    } t_out_item;

    // Records caused by one character, packed from slot zero upward.
    typedef struct packed {
        t_out_item [REC_MAX-1:0] recs;
        logic [REC_CNT_W-1:0]    count;
    } t_rec_batch;

    function automatic t_out_item mk_rec(logic [2:0] kind, t_pos start, t_pos len);
        t_out_item r;
        r.part_kind   = kind;
        r.part_start  = 32'(start);
        r.part_length = 32'(len);
        r.run_end     = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/properties_text_tokenizer_unit.sv -----
// Top level of the properties text tokenizer: input register, scanner and
// result register. Depends on ptt_pkg, ptt_in_reg, ptt_scan and ptt_rec_queue.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | i_in_valid / o_in_stall | i_in_item (one character)
//   out     | source    | o_out_valid / i_out_stall | o_out_item (one part record)
//
// A character item is held in the input register; the scanner then hands its
// records to the result register, which presents them on the output in slot
// order. The result register gives out one record per cycle while the output
// is not stalled, and the next character leaves the input register once the
// last record of the previous one is being taken or none is left.
// Reset is synchronous and active low; it clears valids and the parse state.
// A stall on the output holds the result register and, through it, the input.
module properties_text_tokenizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptt_pkg::t_out_item o_out_item
);

    logic                in_valid;
    ptt_pkg::t_in_item   in_item;
    ptt_pkg::t_rec_batch batch;
    logic                q_free;
    logic                advance;

    // The held character moves on as soon as the result register will be
    // empty at the next edge; characters that yield no record move on too.
    assign advance = in_valid && q_free;

    ptt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // Parse state and position advance only when the character is taken.
    ptt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (in_item),
        .o_batch   (batch)
    );

    ptt_rec_queue u_rec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_batch (batch),
        .o_free  (q_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// ----- src/ptt_in_reg.sv -----
// Input register of the properties text tokenizer.
// Holds one character item until the scanner takes it; uses ptt_pkg.
module ptt_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptt_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_take,
    output logic              o_valid,
    output ptt_pkg::t_in_item o_item
);

    logic              r_valid;
    ptt_pkg::t_in_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/ptt_scan.sv -----
// Parse state and record builder of the properties text tokenizer.
// Turns one character into up to four part records; uses ptt_pkg.
module ptt_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  ptt_pkg::t_in_item   i_item,
    output ptt_pkg::t_rec_batch o_batch
);

    logic [2:0]    r_mode, n_mode;
    logic          r_esc, n_esc;
    ptt_pkg::t_pos r_pos, n_pos;
    ptt_pkg::t_pos r_pb, n_pb;

    ptt_pkg::t_char c;
    ptt_pkg::t_pos  nx;
    logic is_b, is_nl, is_sep, is_cm, is_bs, last;

    // Candidate records in emission order.
    logic [2:0]    main_kind, fl_kind;
    ptt_pkg::t_pos main_start;
    logic          e_bl, e_main, e_sep, e_fl, e_fv;
    logic [2:0]    m_mode;
    logic          m_esc;
    ptt_pkg::t_pos m_pb;

    ptt_pkg::t_out_item [4:0] cand;
    logic [4:0]               cand_v;

    always_comb begin
        c      = i_item.char_code[ptt_pkg::CHAR_WIDTH-1:0];
        last   = i_item.final_char;
        nx     = r_pos + ptt_pkg::POS_WIDTH'(1);
        is_nl  = (c == ptt_pkg::CH_LF) || (c == ptt_pkg::CH_CR);
        is_b   = c inside {ptt_pkg::CH_SPACE, ptt_pkg::CH_TAB, ptt_pkg::CH_FF,
                           ptt_pkg::CH_LF, ptt_pkg::CH_CR};
        is_sep = (c == ptt_pkg::CH_EQUAL) || (c == ptt_pkg::CH_COLON);
        is_cm  = (c == ptt_pkg::CH_HASH) || (c == ptt_pkg::CH_BANG);
        is_bs  = (c == ptt_pkg::CH_BSL);

        m_mode     = r_mode;
        m_esc      = r_esc;
        m_pb       = r_pb;
        e_bl       = 1'b0;
        e_main     = 1'b0;
        e_sep      = 1'b0;
        main_kind  = ptt_pkg::KIND_KEY;
        main_start = r_pb;

        case (r_mode)
            ptt_pkg::MODE_LEAD: begin
                if (!is_b) begin
                    e_bl = (r_pos != r_pb);
                    m_pb = r_pos;
                    if (is_cm) begin
                        m_mode = ptt_pkg::MODE_COMMENT;
                    end else if (is_sep) begin
                        // Empty key directly followed by its separator.
                        e_main     = 1'b1;
                        main_start = r_pos;
                        e_sep      = 1'b1;
                        m_esc      = 1'b0;
                        m_mode     = ptt_pkg::MODE_GAP_SEP;
                        m_pb       = nx;
                    end else begin
                        m_mode = ptt_pkg::MODE_KEY;
                        m_esc  = is_bs;
                    end
                end
            end
            ptt_pkg::MODE_COMMENT: begin
                if (is_nl) begin
                    e_main    = 1'b1;
                    main_kind = ptt_pkg::KIND_COMMENT;
                    m_mode    = ptt_pkg::MODE_LEAD;
                    m_pb      = r_pos;
                end
            end
            ptt_pkg::MODE_KEY: begin
                if (!r_esc && (is_sep || is_b)) begin
                    e_main = 1'b1;
                    if (is_b) begin
                        m_mode = ptt_pkg::MODE_GAP_KEY;
                        m_pb   = r_pos;
                    end else begin
                        e_sep  = 1'b1;
                        m_mode = ptt_pkg::MODE_GAP_SEP;
                        m_pb   = nx;
                    end
                end else begin
                    m_esc = is_bs && !r_esc;
                end
            end
            ptt_pkg::MODE_GAP_KEY: begin
                if (!is_b) begin
                    e_bl = (r_pos != r_pb);
                    if (is_sep) begin
                        e_sep  = 1'b1;
                        m_mode = ptt_pkg::MODE_GAP_SEP;
                        m_pb   = nx;
                    end else begin
                        m_mode = ptt_pkg::MODE_VALUE;
                        m_pb   = r_pos;
                        m_esc  = is_bs;
                    end
                end
            end
            ptt_pkg::MODE_GAP_SEP: begin
                if (!is_b) begin
                    e_bl   = (r_pos != r_pb);
                    m_mode = ptt_pkg::MODE_VALUE;
                    m_pb   = r_pos;
                    m_esc  = is_bs;
                end
            end
            default: begin
                if (!r_esc && is_nl) begin
                    e_main    = 1'b1;
                    main_kind = ptt_pkg::KIND_VALUE;
                    m_mode    = ptt_pkg::MODE_LEAD;
                    m_pb      = r_pos;
                end else begin
                    m_esc = is_bs && !r_esc;
                end
            end
        endcase

        // Flush of open parts after the final character.
        e_fl    = 1'b0;
        e_fv    = 1'b0;
        fl_kind = ptt_pkg::KIND_BLANKS;
        if (last) begin
            case (m_mode)
                ptt_pkg::MODE_LEAD: begin
                    e_fl = (nx != m_pb);
                end
                ptt_pkg::MODE_COMMENT: begin
                    e_fl    = 1'b1;
                    fl_kind = ptt_pkg::KIND_COMMENT;
                end
                ptt_pkg::MODE_KEY: begin
                    e_fl    = 1'b1;
                    fl_kind = ptt_pkg::KIND_KEY;
                    e_fv    = 1'b1;
                end
                ptt_pkg::MODE_GAP_KEY, ptt_pkg::MODE_GAP_SEP: begin
                    e_fl = (nx != m_pb);
                    e_fv = 1'b1;
                end
                default: begin
                    e_fl    = 1'b1;
                    fl_kind = ptt_pkg::KIND_VALUE;
                end
            endcase
        end

        cand[0] = ptt_pkg::mk_rec(ptt_pkg::KIND_BLANKS, r_pb, r_pos - r_pb);
        cand[1] = ptt_pkg::mk_rec(main_kind, main_start, r_pos - main_start);
        cand[2] = ptt_pkg::mk_rec(ptt_pkg::KIND_SEP, r_pos, ptt_pkg::POS_WIDTH'(1));
        cand[3] = ptt_pkg::mk_rec(fl_kind, m_pb, nx - m_pb);
        cand[4] = ptt_pkg::mk_rec(ptt_pkg::KIND_VALUE, nx, '0);
        cand_v  = {e_fv, e_fl, e_sep, e_main, e_bl};

        if (last) begin
            n_mode = ptt_pkg::MODE_LEAD;
            n_esc  = 1'b0;
            n_pos  = '0;
            n_pb   = '0;
        end else begin
            n_mode = m_mode;
            n_esc  = m_esc;
            n_pos  = nx;
            n_pb   = m_pb;
        end
    end

    // Pack the chosen candidates into consecutive slots and mark the last one.
    always_comb begin
        logic [ptt_pkg::REC_CNT_W-1:0] idx;
        idx            = '0;
        o_batch.recs   = '0;
        for (int i = 0; i < 5; i++) begin
            if (cand_v[i] && (idx < ptt_pkg::REC_CNT_W'(ptt_pkg::REC_MAX))) begin
                o_batch.recs[idx[$clog2(ptt_pkg::REC_MAX)-1:0]] = cand[i];
                idx = idx + ptt_pkg::REC_CNT_W'(1);
            end
        end
        for (int j = 0; j < ptt_pkg::REC_MAX; j++) begin
            o_batch.recs[j].run_end =
                (ptt_pkg::REC_CNT_W'(j) + ptt_pkg::REC_CNT_W'(1) == idx);
        end
        o_batch.count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ptt_pkg::MODE_LEAD;
            r_esc  <= 1'b0;
            r_pos  <= '0;
            r_pb   <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_pos  <= n_pos;
            r_pb   <= n_pb;
        end
    end

endmodule

// ----- src/ptt_rec_queue.sv -----
// Result register of the properties text tokenizer: holds the records of
// one character and hands them out one per item; uses ptt_pkg.
module ptt_rec_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ptt_pkg::t_rec_batch i_batch,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output ptt_pkg::t_out_item  o_item
);

    ptt_pkg::t_out_item [ptt_pkg::REC_MAX-1:0] r_recs, n_recs;
    logic [ptt_pkg::REC_CNT_W-1:0]              r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_recs[0];
    assign o_free  = (r_cnt == '0) ||
                     ((r_cnt == ptt_pkg::REC_CNT_W'(1)) && !i_stall);

    always_comb begin
        n_recs = r_recs;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_recs = i_batch.recs;
            n_cnt  = i_batch.count;
        end else if (o_valid && !i_stall) begin
            for (int j = 0; j < ptt_pkg::REC_MAX - 1; j++) begin
                n_recs[j] = r_recs[j+1];
            end
            n_cnt = r_cnt - ptt_pkg::REC_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_recs <= n_recs;
    end

endmodule
